// ===== sv/cla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_pkg
// Shared constants and types for the command line assembler with e-stop
// watch.
// ----------------------------------------------------------------------------
package cla_pkg;

   localparam int LINE_CHARS_DEFAULT = 63;

   localparam logic [7:0] CH_M   = 8'h4D;
   localparam logic [7:0] CH_ONE = 8'h31;
   localparam logic [7:0] CH_TWO = 8'h32;
   localparam logic [7:0] CH_NL  = 8'h0A;

   localparam logic [1:0] ST_EMPTY    = 2'd0;
   localparam logic [1:0] ST_BUILDING = 2'd1;
   localparam logic [1:0] ST_READY    = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [1:0] MS_IDLE = 2'd0;
   localparam logic [1:0] MS_M    = 2'd1;
   localparam logic [1:0] MS_M1   = 2'd2;
   localparam logic [1:0] MS_M11  = 2'd3;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   typedef struct packed {
      logic       consumed;
      logic       stop;
      logic [1:0] wb_count;
   } match_result_type;

endpackage

// ===== sv/cla_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cla_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_matcher
// Watches the byte stream for the e-stop sequence and holds back its
// prefixes; reports how many held characters must go back into the line.
// ----------------------------------------------------------------------------
module cla_matcher (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                data_byte,
   output cla_pkg::match_result_type res
);

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      res      = '0;
      state_in = cla_pkg::MS_IDLE;
      case (state_ff)
         cla_pkg::MS_IDLE: begin
            if (data_byte == cla_pkg::CH_M) begin
               state_in     = cla_pkg::MS_M;
               res.consumed = 1'b1;
            end
         end
         cla_pkg::MS_M: begin
            if (data_byte == cla_pkg::CH_ONE) begin
               state_in     = cla_pkg::MS_M1;
               res.consumed = 1'b1;
            end else begin
               res.wb_count = 2'd1;
            end
         end
         cla_pkg::MS_M1: begin
            if (data_byte == cla_pkg::CH_ONE) begin
               state_in     = cla_pkg::MS_M11;
               res.consumed = 1'b1;
            end else begin
               res.wb_count = 2'd2;
            end
         end
         default: begin
            if (data_byte == cla_pkg::CH_TWO) begin
               res.consumed = 1'b1;
               res.stop     = 1'b1;
            end else begin
               res.wb_count = 2'd3;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cla_pkg::MS_IDLE;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_wb_not_consumed: assert property (@(posedge clock) disable iff (reset)
      (res.wb_count != 2'd0) |-> !res.consumed)
      else $error("write-back requested on a consumed byte");

   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      (step && res.stop) |=> (state_ff == cla_pkg::MS_IDLE))
      else $error("matcher not idle after stop");
`endif

endmodule

// ===== sv/command_line_assembler_with_estop_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_assembler_with_estop_core
// Assembles received bytes into a command line held in a RAM, watches for
// the e-stop sequence, and plays the stored line back on a take.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  req_opcode, req_data_byte
//   rsp_     out  rsp_valid/rsp_stall  byte_accepted .. last (7 fields)
//
// a byte word passes through one write-back step per held character (up to
// 3) and then the byte step, as the RAM has a single write port
// a take starts with a read step, then a read and an emit step per line
// character and an end marker step, paced by the registered RAM read
// synchronous reset clears the line status, index and matcher; no sweep
// a waiting result word does not block acceptance; only the steps that
// load a result word wait for the output register to free up
// ----------------------------------------------------------------------------
module command_line_assembler_with_estop_core #(
   parameter int LINE_CHARS = cla_pkg::LINE_CHARS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_byte_accepted,
   output logic       rsp_send_ok,
   output logic       rsp_shutdown,
   output logic       rsp_line_ready,
   output logic       rsp_is_line_char,
   output logic [7:0] rsp_line_char,
   output logic       rsp_last
);

   localparam int AW = $clog2(LINE_CHARS);
   localparam int IW = $clog2(LINE_CHARS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WB   = 3'd1;
   localparam logic [2:0] S_BYTE = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_END  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]    byte_ff, byte_in;
   logic          consumed_ff, consumed_in;
   logic          stop_ff, stop_in;
   logic [1:0]    wb_n_ff, wb_n_in;
   logic [1:0]    wb_pos_ff, wb_pos_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          acc_ff, acc_in;
   logic          ok_ff, ok_in;
   logic          shut_ff, shut_in;
   logic          ready_ff, ready_in;
   logic          is_char_ff, is_char_in;
   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [7:0]    rd_data;
   logic          step;
   logic          rsp_free;
   logic          room;
   logic [IW:0]   idx_sum;
   logic          load_rsp;

   cla_pkg::match_result_type mres;

   cla_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_data_byte),
      .res       (mres)
   );

   cla_ram #(
      .WIDTH (8),
      .DEPTH (LINE_CHARS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign step      = req_valid && !req_stall && (req_opcode == cla_pkg::OP_BYTE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign room      = (idx_ff < IW'(LINE_CHARS));
   assign idx_sum   = {1'b0, idx_ff} + {{IW{1'b0}}, 1'b1};

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      rd_idx_in   = rd_idx_ff;
      byte_in     = byte_ff;
      consumed_in = consumed_ff;
      stop_in     = stop_ff;
      wb_n_in     = wb_n_ff;
      wb_pos_in   = wb_pos_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_data     = 8'h00;
      rd_en       = 1'b0;
      load_rsp    = 1'b0;
      acc_in      = acc_ff;
      ok_in       = ok_ff;
      shut_in     = shut_ff;
      ready_in    = ready_ff;
      is_char_in  = is_char_ff;
      char_in     = char_ff;
      last_in     = last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == cla_pkg::OP_TAKE) begin
                  rd_idx_in = '0;
                  state_in  = S_RD;
               end else begin
                  byte_in     = req_data_byte;
                  consumed_in = mres.consumed;
                  stop_in     = mres.stop;
                  wb_n_in     = mres.wb_count;
                  wb_pos_in   = 2'd0;
                  state_in    = (mres.wb_count != 2'd0) ? S_WB : S_BYTE;
               end
            end
         end
         S_WB: begin
            if (status_ff != cla_pkg::ST_READY && status_ff != cla_pkg::ST_OVERFLOW
                && room) begin
               wr_en     = 1'b1;
               wr_data   = (wb_pos_ff == 2'd0) ? cla_pkg::CH_M : cla_pkg::CH_ONE;
               idx_in    = idx_sum[IW-1:0];
               status_in = cla_pkg::ST_BUILDING;
            end
            wb_pos_in = wb_pos_ff + 2'd1;
            if (wb_pos_ff + 2'd1 == wb_n_ff) begin
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               acc_in   = consumed_ff;
               ok_in    = stop_ff;
               shut_in  = stop_ff;
               if (!consumed_ff && status_ff != cla_pkg::ST_READY) begin
                  acc_in = 1'b1;
                  if (byte_ff == cla_pkg::CH_NL) begin
                     wr_en     = room;
                     wr_data   = 8'h00;
                     idx_in    = '0;
                     status_in = cla_pkg::ST_READY;
                     ok_in     = 1'b1;
                  end else if (status_ff != cla_pkg::ST_OVERFLOW) begin
                     wr_en   = room;
                     wr_data = byte_ff;
                     if (idx_sum >= (IW + 1)'(LINE_CHARS)) begin
                        idx_in    = '0;
                        status_in = cla_pkg::ST_OVERFLOW;
                     end else begin
                        idx_in    = idx_sum[IW-1:0];
                        status_in = cla_pkg::ST_BUILDING;
                     end
                  end
               end
               ready_in   = (status_in == cla_pkg::ST_READY);
               is_char_in = 1'b0;
               char_in    = 8'h00;
               last_in    = 1'b0;
               state_in   = S_IDLE;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               acc_in   = 1'b0;
               ok_in    = 1'b0;
               shut_in  = 1'b0;
               ready_in = 1'b0;
               if (rd_data == 8'h00) begin
                  is_char_in = 1'b0;
                  char_in    = 8'h00;
                  last_in    = 1'b1;
                  idx_in     = '0;
                  status_in  = cla_pkg::ST_EMPTY;
                  state_in   = S_IDLE;
               end else begin
                  is_char_in = 1'b1;
                  char_in    = rd_data;
                  last_in    = 1'b0;
                  if (rd_idx_ff == AW'(LINE_CHARS - 1)) begin
                     state_in = S_END;
                  end else begin
                     rd_idx_in = rd_idx_ff + {{(AW-1){1'b0}}, 1'b1};
                     state_in  = S_RD;
                  end
               end
            end
         end
         S_END: begin
            if (rsp_free) begin
               load_rsp   = 1'b1;
               acc_in     = 1'b0;
               ok_in      = 1'b0;
               shut_in    = 1'b0;
               ready_in   = 1'b0;
               is_char_in = 1'b0;
               char_in    = 8'h00;
               last_in    = 1'b1;
               idx_in     = '0;
               status_in  = cla_pkg::ST_EMPTY;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         status_ff    <= cla_pkg::ST_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      byte_ff     <= byte_in;
      consumed_ff <= consumed_in;
      stop_ff     <= stop_in;
      wb_n_ff     <= wb_n_in;
      wb_pos_ff   <= wb_pos_in;
      acc_ff      <= acc_in;
      ok_ff       <= ok_in;
      shut_ff     <= shut_in;
      ready_ff    <= ready_in;
      is_char_ff  <= is_char_in;
      char_ff     <= char_in;
      last_ff     <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_accepted = acc_ff;
   assign rsp_send_ok       = ok_ff;
   assign rsp_shutdown      = shut_ff;
   assign rsp_line_ready    = ready_ff;
   assign rsp_is_line_char  = is_char_ff;
   assign rsp_line_char     = char_ff;
   assign rsp_last          = last_ff;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("block idle right after taking a word");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IW'(LINE_CHARS))
      else $error("write index beyond line length");

   a_index_cleared: assert property (@(posedge clock) disable iff (reset)
      (status_ff == cla_pkg::ST_READY || status_ff == cla_pkg::ST_OVERFLOW)
      |-> (idx_ff == '0))
      else $error("write index not cleared in ready or overflow");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_WB || state_ff == S_BYTE))
      else $error("line store written outside a byte word");
`endif

endmodule

// ===== tb/command_line_assembler_with_estop_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_assembler_with_estop_core_tb
// Self-checking bench for the command line assembler. A short table of
// directed words covers byte extremes, refusal while a line is ready,
// dropped and kept write-backs, the e-stop sequence and takes with and
// without a ready line. Random command lines follow: mostly short, a few
// long enough to overflow, with the e-stop prefixes seeded in. Each result
// word is checked against its table row or the in-bench line/matcher model.
// Both sides idle at random, and the result side holds off once for a long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------
module command_line_assembler_with_estop_core_tb;

   localparam int LINE_LEN        = cla_pkg::LINE_CHARS_DEFAULT;
   localparam int STALL_LIMIT     = 3000;
   localparam int HOLD_CYCLES     = 400;
   localparam int ITEMS_PER_PHASE = 140;

   typedef struct packed {
      logic       accepted;
      logic       ok;
      logic       stop;
      logic       ready;
      logic       is_char;
      logic [7:0] ch;
      logic       last;
   } rsp_fields_type;

   typedef struct packed {
      logic           op;
      logic [7:0]     data;
      logic           typed;
      rsp_fields_type want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_opcode = cla_pkg::OP_BYTE;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_byte_accepted;
   logic       rsp_send_ok;
   logic       rsp_shutdown;
   logic       rsp_line_ready;
   logic       rsp_is_line_char;
   logic [7:0] rsp_line_char;
   logic       rsp_last;

   // model of the line store and matcher
   logic [7:0] line_mem [64];
   bit         line_mem_set [64];
   logic [6:0] wr_idx;
   logic [1:0] line_st;
   logic [1:0] match_st;

   rsp_fields_type step_words [$];
   rsp_fields_type awaited_rsp [$];
   stim_row_type   dir_rows [$];

   int fail_count = 0;
   int items_sent = 0;
   int idle_run = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int tx_idle_pct = 15;
   int rx_idle_pct = 71;
   bit pressure_on = 1'b0;

   command_line_assembler_with_estop_core #(
      .LINE_CHARS(LINE_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_byte_accepted(rsp_byte_accepted),
      .rsp_send_ok(rsp_send_ok),
      .rsp_shutdown(rsp_shutdown),
      .rsp_line_ready(rsp_line_ready),
      .rsp_is_line_char(rsp_is_line_char),
      .rsp_line_char(rsp_line_char),
      .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_assembler();
      for (int i = 0; i < 64; i++) line_mem_set[i] = 1'b0;
      wr_idx   = '0;
      line_st  = cla_pkg::ST_EMPTY;
      match_st = cla_pkg::MS_IDLE;
   endfunction

   function automatic void put_char(input logic [7:0] c);
      line_mem[wr_idx[5:0]]     = c;
      line_mem_set[wr_idx[5:0]] = 1'b1;
   endfunction

   function automatic void store_held(input logic [7:0] c);
      if (line_st == cla_pkg::ST_READY || line_st == cla_pkg::ST_OVERFLOW) return;
      if (wr_idx < LINE_LEN) begin
         put_char(c);
         wr_idx  = wr_idx + 7'd1;
         line_st = cla_pkg::ST_BUILDING;
      end
   endfunction

   function automatic bit take_is_safe();
      for (int i = 0; i < LINE_LEN; i++) begin
         if (!line_mem_set[i]) return 1'b0;
         if (line_mem[i] == 8'h00) return 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic void assemble_step(input logic op, input logic [7:0] b);
      rsp_fields_type w;
      logic           consumed;
      step_words.delete();
      w = '0;
      if (op == cla_pkg::OP_TAKE) begin
         for (int i = 0; i < LINE_LEN; i++) begin
            if (line_mem[i] == 8'h00) break;
            w         = '0;
            w.is_char = 1'b1;
            w.ch      = line_mem[i];
            step_words.push_back(w);
         end
         w      = '0;
         w.last = 1'b1;
         step_words.push_back(w);
         wr_idx  = '0;
         line_st = cla_pkg::ST_EMPTY;
         return;
      end
      consumed = 1'b0;
      case (match_st)
         cla_pkg::MS_IDLE: begin
            if (b == cla_pkg::CH_M) begin
               match_st = cla_pkg::MS_M;
               consumed = 1'b1;
            end
         end
         cla_pkg::MS_M: begin
            if (b == cla_pkg::CH_ONE) begin
               match_st = cla_pkg::MS_M1;
               consumed = 1'b1;
            end else begin
               store_held(cla_pkg::CH_M);
               match_st = cla_pkg::MS_IDLE;
            end
         end
         cla_pkg::MS_M1: begin
            if (b == cla_pkg::CH_ONE) begin
               match_st = cla_pkg::MS_M11;
               consumed = 1'b1;
            end else begin
               store_held(cla_pkg::CH_M);
               store_held(cla_pkg::CH_ONE);
               match_st = cla_pkg::MS_IDLE;
            end
         end
         default: begin
            if (b == cla_pkg::CH_TWO) begin
               w.ok     = 1'b1;
               w.stop   = 1'b1;
               match_st = cla_pkg::MS_IDLE;
               consumed = 1'b1;
            end else begin
               store_held(cla_pkg::CH_M);
               store_held(cla_pkg::CH_ONE);
               store_held(cla_pkg::CH_ONE);
               match_st = cla_pkg::MS_IDLE;
            end
         end
      endcase
      if (consumed) begin
         w.accepted = 1'b1;
      end else if (line_st != cla_pkg::ST_READY) begin
         w.accepted = 1'b1;
         if (b == cla_pkg::CH_NL) begin
            if (wr_idx < LINE_LEN) put_char(8'h00);
            wr_idx  = '0;
            line_st = cla_pkg::ST_READY;
            w.ok    = 1'b1;
         end else if (line_st != cla_pkg::ST_OVERFLOW) begin
            put_char(b);
            wr_idx  = wr_idx + 7'd1;
            line_st = cla_pkg::ST_BUILDING;
            if (wr_idx >= LINE_LEN) begin
               wr_idx  = '0;
               line_st = cla_pkg::ST_OVERFLOW;
            end
         end
      end
      w.ready = (line_st == cla_pkg::ST_READY);
      step_words.push_back(w);
   endfunction

   function automatic void add_row(input logic op, input logic [7:0] b, input logic typed,
                                   input logic [3:0] flags);
      stim_row_type r;
      r       = '0;
      r.op    = op;
      r.data  = b;
      r.typed = typed;
      {r.want.accepted, r.want.ok, r.want.stop, r.want.ready} = flags;
      dir_rows.push_back(r);
   endfunction

   task automatic send_word(input logic op, input logic [7:0] b, input logic typed,
                            input rsp_fields_type want);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      assemble_step(op, b);
      if (typed) awaited_rsp.push_back(want);
      else foreach (step_words[i]) awaited_rsp.push_back(step_words[i]);
      if (op == cla_pkg::OP_TAKE || step_words[0].accepted) items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(cla_pkg::OP_BYTE, b, 1'b0, '0);
   endtask

   task automatic send_line();
      int len;
      int pick;
      len = ($urandom_range(99) < 15) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      for (int n = 0; n < len; n++) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_byte(cla_pkg::CH_M);
            send_byte(cla_pkg::CH_ONE);
            send_byte(cla_pkg::CH_ONE);
            send_byte(cla_pkg::CH_TWO);
         end else if (pick < 25) send_byte(cla_pkg::CH_M);
         else if (pick < 40) send_byte(cla_pkg::CH_ONE);
         else if (pick < 47) send_byte(cla_pkg::CH_TWO);
         else if (pick < 50) send_byte(8'h00);
         else send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(99) < 85) send_byte(cla_pkg::CH_NL);
      // stray bytes, often refused while the line waits
      if ($urandom_range(99) < 25) begin
         repeat ($urandom_range(1, 3)) begin
            send_byte(($urandom_range(1) == 0) ? cla_pkg::CH_M : 8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(99) < 80 && take_is_safe())
         send_word(cla_pkg::OP_TAKE, 8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // result side
   always @(posedge clock) begin
      rsp_fields_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $error("result word arrived with none expected");
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("rsp_byte_accepted", want.accepted, rsp_byte_accepted);
            check_field("rsp_send_ok", want.ok, rsp_send_ok);
            check_field("rsp_shutdown", want.stop, rsp_shutdown);
            check_field("rsp_line_ready", want.ready, rsp_line_ready);
            check_field("rsp_is_line_char", want.is_char, rsp_is_line_char);
            check_field("rsp_line_char", want.ch, rsp_line_char);
            check_field("rsp_last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (pressure_on && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_run = 0;
      end else begin
         idle_run++;
         if (idle_run >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      clear_assembler();
      //      op                byte            typed  acc ok stop rdy
      add_row(cla_pkg::OP_BYTE, 8'h47,          1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, 8'h00,          1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, 8'hFF,          1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_NL,  1'b1, 4'b1101);
      add_row(cla_pkg::OP_BYTE, 8'h58,          1'b1, 4'b0001);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_M,   1'b1, 4'b1001);
      add_row(cla_pkg::OP_BYTE, 8'h41,          1'b1, 4'b0001);
      add_row(cla_pkg::OP_TAKE, 8'hFF,          1'b0, 4'b0000);
      add_row(cla_pkg::OP_TAKE, 8'h00,          1'b0, 4'b0000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_M,   1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_ONE, 1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_ONE, 1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_TWO, 1'b1, 4'b1110);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_M,   1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_M,   1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_M,   1'b0, 4'b0000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_ONE, 1'b0, 4'b0000);
      add_row(cla_pkg::OP_BYTE, 8'h5A,          1'b0, 4'b0000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_M,   1'b0, 4'b0000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_ONE, 1'b0, 4'b0000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_ONE, 1'b0, 4'b0000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_NL,  1'b1, 4'b1101);
      add_row(cla_pkg::OP_TAKE, 8'h5A,          1'b0, 4'b0000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_M,   1'b1, 4'b1000);
      add_row(cla_pkg::OP_BYTE, cla_pkg::CH_NL,  1'b1, 4'b1101);
      add_row(cla_pkg::OP_TAKE, 8'h80,          1'b0, 4'b0000);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      while (items_sent < ITEMS_PER_PHASE) send_line();

      tx_idle_pct = 71;
      rx_idle_pct = 15;
      while (items_sent < 2 * ITEMS_PER_PHASE) send_line();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      pressure_on = 1'b1;
      while (items_sent < 3 * ITEMS_PER_PHASE) send_line();
      req_valid <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/cla_pkg.sv
sv/cla_ram.sv
sv/cla_matcher.sv
sv/command_line_assembler_with_estop_core.sv
tb/command_line_assembler_with_estop_core_tb.sv
